@@ hdl/rau_pkg.sv @@
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

  localparam logic [2:0] MODE_NORM = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;
  localparam logic [2:0] MODE_CMP  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [1:0] MUL_P1 = 2'd0;
  localparam logic [1:0] MUL_P2 = 2'd1;
  localparam logic [1:0] MUL_P3 = 2'd2;

  // Which fraction register a reduction reads and writes back.
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_R
  } rau_sel_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic [1:0]         status;
  } rau_out_t;

  typedef struct packed {
    logic       load;
    logic       red_load;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       red_store;
    logic       mul_en;
    logic [1:0] mul_idx;
    rau_sel_e   sel;
    logic       finish;
    logic [1:0] st_code;
  } rau_cmd_t;

  typedef struct packed {
    logic       a_den_zero;
    logic       b_den_zero;
    logic       b_num_zero;
    logic       gcd_done;
    logic       div_done;
    logic       red_ovf;
    logic [2:0] mode;
  } rau_stat_t;

endpackage

@@ hdl/rau_datapath.sv @@
// Datapath: operand registers, shared multiplier, binary gcd and bit-serial divider.
module rau_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  rau_pkg::rau_in_t  in_data_i,
  input  rau_pkg::rau_cmd_t cmd_i,
  output rau_pkg::rau_stat_t stat_o,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  localparam int unsigned EW = (WIDTH < 32) ? WIDTH : 32;
  localparam int unsigned DW = 2 * EW;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned KW = $clog2(DW + 1);
  localparam logic [DW-1:0] LIM = DW'((64'd1 << (EW - 1)) - 64'd1);

  logic [2:0]    mode_q;
  logic          an_q, bn_q, rn_q, neg_q;
  logic [EW-1:0] am_q, ad_q, bm_q, bd_q, rm_q, rd_q;
  logic [DW-1:0] p1_q, p2_q, p3_q;
  logic [DW-1:0] u_q, v_q, qn_q, qd_q, remn_q, remd_q;
  logic [KW-1:0] k_q;
  logic [CW-1:0] cnt_q;
  rau_out_t      out_q;

  // Input decode to sign and magnitude.
  logic [EW-1:0] an_raw, ad_raw, bn_raw, am_raw, adm_raw, bm_raw, bd_raw;
  logic [2:0]    mode_in;
  assign an_raw  = in_data_i.a_num[EW-1:0];
  assign ad_raw  = in_data_i.a_den[EW-1:0];
  assign bn_raw  = in_data_i.b_num[EW-1:0];
  assign am_raw  = an_raw[EW-1] ? EW'(-an_raw) : an_raw;
  assign adm_raw = ad_raw[EW-1] ? EW'(-ad_raw) : ad_raw;
  assign bm_raw  = bn_raw[EW-1] ? EW'(-bn_raw) : bn_raw;
  assign bd_raw  = EW'(in_data_i.b_den[EW-2:0]);
  assign mode_in = (in_data_i.mode > MODE_CMP) ? MODE_NORM : in_data_i.mode;

  // Cross product sums for add, subtract and compare.
  logic [DW:0] sa, sb, ssum, sbv;
  logic        sb_neg;
  assign sb_neg = bn_q ^ (mode_q == MODE_SUB);
  assign sa     = an_q ? -{1'b0, p1_q} : {1'b0, p1_q};
  assign sb     = sb_neg ? -{1'b0, p2_q} : {1'b0, p2_q};
  assign ssum   = sa + sb;
  assign sbv    = bn_q ? -{1'b0, p2_q} : {1'b0, p2_q};

  logic          ld_neg;
  logic [DW-1:0] ld_n, ld_d;
  always_comb begin
    ld_neg = neg_q;
    ld_n   = '0;
    ld_d   = '0;
    case (cmd_i.sel)
      SEL_A: begin
        ld_neg = an_q;
        ld_n   = DW'(am_q);
        ld_d   = DW'(ad_q);
      end
      SEL_B: begin
        ld_neg = bn_q;
        ld_n   = DW'(bm_q);
        ld_d   = DW'(bd_q);
      end
      default: begin
        ld_d = p3_q;
        if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
          ld_neg = ssum[DW];
          ld_n   = ssum[DW] ? DW'(-ssum) : ssum[DW-1:0];
        end else begin
          ld_neg = an_q ^ bn_q;
          ld_n   = p1_q;
        end
      end
    endcase
  end

  // Multiplier operand selection.
  logic [EW-1:0] mx, my;
  logic [DW-1:0] prod;
  always_comb begin
    case (cmd_i.mul_idx)
      MUL_P1: begin
        mx = am_q;
        my = (mode_q == MODE_MUL) ? bm_q : bd_q;
      end
      MUL_P2: begin
        mx = bm_q;
        my = ad_q;
      end
      default: begin
        mx = ad_q;
        my = (mode_q == MODE_DIV) ? bm_q : bd_q;
      end
    endcase
  end
  assign prod = mx * my;

  // Binary gcd step.
  logic [DW:0] d_uv, d_vu;
  assign d_uv = {1'b0, u_q} - {1'b0, v_q};
  assign d_vu = {1'b0, v_q} - {1'b0, u_q};

  // Restoring division step, numerator and denominator side by side.
  logic [DW:0]   tn, td;
  logic          gen, ged;
  logic [DW-1:0] remn_nx, remd_nx;
  assign tn      = {remn_q, qn_q[DW-1]};
  assign td      = {remd_q, qd_q[DW-1]};
  assign gen     = tn >= {1'b0, v_q};
  assign ged     = td >= {1'b0, v_q};
  assign remn_nx = gen ? DW'(tn - {1'b0, v_q}) : tn[DW-1:0];
  assign remd_nx = ged ? DW'(td - {1'b0, v_q}) : td[DW-1:0];

  logic red_ovf;
  assign red_ovf = (qd_q > LIM) || (qn_q > (LIM + DW'(neg_q)));

  // Result formatting.
  logic          less, equal;
  logic [EW-1:0] fmag, fden, fnum;
  logic          fneg;
  assign less  = $signed(sa) < $signed(sbv);
  assign equal = (an_q == bn_q) && (am_q == bm_q) && (ad_q == bd_q);
  always_comb begin
    if (mode_q == MODE_NORM) begin
      fneg = an_q;
      fmag = am_q;
      fden = ad_q;
    end else begin
      fneg = rn_q;
      fmag = rm_q;
      fden = rd_q;
    end
  end
  assign fnum = fneg ? EW'(-fmag) : fmag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_in;
      an_q   <= (am_raw != '0) && (an_raw[EW-1] != ad_raw[EW-1]);
      am_q   <= am_raw;
      ad_q   <= adm_raw;
      bn_q   <= bn_raw[EW-1];
      bm_q   <= bm_raw;
      bd_q   <= bd_raw;
    end
    if (cmd_i.red_load) begin
      neg_q <= ld_neg;
      qn_q  <= ld_n;
      qd_q  <= ld_d;
      u_q   <= ld_n;
      v_q   <= ld_d;
      k_q   <= '0;
    end
    if (cmd_i.gcd_step && u_q != '0) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (!d_uv[DW]) begin
        u_q <= DW'(d_uv[DW-1:1]);
      end else begin
        v_q <= DW'(d_vu[DW-1:1]);
      end
    end
    if (cmd_i.div_init) begin
      qn_q   <= qn_q >> k_q;
      qd_q   <= qd_q >> k_q;
      remn_q <= '0;
      remd_q <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      qn_q   <= {qn_q[DW-2:0], gen};
      qd_q   <= {qd_q[DW-2:0], ged};
      remn_q <= remn_nx;
      remd_q <= remd_nx;
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.red_store) begin
      case (cmd_i.sel)
        SEL_A: begin
          an_q <= neg_q && (qn_q != '0);
          am_q <= qn_q[EW-1:0];
          ad_q <= qd_q[EW-1:0];
        end
        SEL_B: begin
          bn_q <= neg_q && (qn_q != '0);
          bm_q <= qn_q[EW-1:0];
          bd_q <= qd_q[EW-1:0];
        end
        default: begin
          rn_q <= neg_q && (qn_q != '0);
          rm_q <= qn_q[EW-1:0];
          rd_q <= qd_q[EW-1:0];
        end
      endcase
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_idx)
        MUL_P1:  p1_q <= prod;
        MUL_P2:  p2_q <= prod;
        default: p3_q <= prod;
      endcase
    end
    if (cmd_i.finish) begin
      out_q.status <= cmd_i.st_code;
      if (cmd_i.st_code == ST_OK && mode_q == MODE_CMP) begin
        out_q.res_num  <= '0;
        out_q.res_den  <= 31'd1;
        out_q.is_less  <= less;
        out_q.is_equal <= equal;
      end else if (cmd_i.st_code == ST_OK) begin
        out_q.res_num  <= 32'($signed(fnum));
        out_q.res_den  <= 31'(fden);
        out_q.is_less  <= 1'b0;
        out_q.is_equal <= 1'b0;
      end else begin
        out_q.res_num  <= '0;
        out_q.res_den  <= 31'd1;
        out_q.is_less  <= 1'b0;
        out_q.is_equal <= 1'b0;
      end
    end
  end

  assign stat_o.a_den_zero = (ad_q == '0);
  assign stat_o.b_den_zero = (bd_q == '0);
  assign stat_o.b_num_zero = (bm_q == '0);
  assign stat_o.gcd_done   = (u_q == '0);
  assign stat_o.div_done   = (cnt_q == CW'(DW - 1));
  assign stat_o.red_ovf    = red_ovf;
  assign stat_o.mode       = mode_q;
  assign out_data_o        = out_q;

endmodule

@@ hdl/rau_ctrl.sv @@
// Controller: sequences operand reduction, products, result reduction and output transfer.
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rau_pkg::rau_stat_t stat_i,
  output rau_pkg::rau_cmd_t  cmd_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHKA, S_RLD, S_GCD, S_DINIT, S_DIV, S_RST,
    S_CHKB, S_MUL0, S_MUL1, S_MUL2, S_FIN
  } state_e;

  state_e     state_q;
  rau_sel_e   ph_q;
  logic [1:0] st_q;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.sel     = ph_q;
    cmd_o.st_code = st_q;
    cmd_o.mul_idx = MUL_P1;
    case (state_q)
      S_IDLE:  cmd_o.load      = in_valid_i;
      S_RLD:   cmd_o.red_load  = 1'b1;
      S_GCD:   cmd_o.gcd_step  = 1'b1;
      S_DINIT: cmd_o.div_init  = 1'b1;
      S_DIV:   cmd_o.div_step  = 1'b1;
      S_RST:   cmd_o.red_store = 1'b1;
      S_MUL0:  cmd_o.mul_en    = 1'b1;
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = MUL_P2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = MUL_P3;
      end
      S_FIN:   cmd_o.finish    = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= SEL_A;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            st_q    <= ST_OK;
            state_q <= S_CHKA;
          end
        end
        S_CHKA: begin
          if (stat_i.a_den_zero) begin
            st_q    <= ST_ZDEN;
            state_q <= S_FIN;
          end else begin
            ph_q    <= SEL_A;
            state_q <= S_RLD;
          end
        end
        S_RLD:   state_q <= S_GCD;
        S_GCD:   if (stat_i.gcd_done) state_q <= S_DINIT;
        S_DINIT: state_q <= S_DIV;
        S_DIV:   if (stat_i.div_done) state_q <= S_RST;
        S_RST: begin
          if (stat_i.red_ovf) begin
            st_q    <= ST_OVF;
            state_q <= S_FIN;
          end else begin
            case (ph_q)
              SEL_A:   state_q <= (stat_i.mode == MODE_NORM) ? S_FIN : S_CHKB;
              SEL_B:   state_q <= S_MUL0;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_CHKB: begin
          if (stat_i.b_den_zero) begin
            st_q    <= ST_ZDEN;
            state_q <= S_FIN;
          end else begin
            ph_q    <= SEL_B;
            state_q <= S_RLD;
          end
        end
        S_MUL0: begin
          if (stat_i.mode == MODE_DIV && stat_i.b_num_zero) begin
            st_q    <= ST_DIVZ;
            state_q <= S_FIN;
          end else begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: begin
          if (stat_i.mode == MODE_CMP) begin
            state_q <= S_FIN;
          end else begin
            ph_q    <= SEL_R;
            state_q <= S_RLD;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result not presented after finish");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CHKA))
    else $error("accepted item did not start");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.red_load, cmd_o.gcd_step, cmd_o.div_step, cmd_o.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
//
// Usage: present mode and operands a = a_num/a_den, b = b_num/b_den on in_data_i with
// in_valid_i; the item transfers on a clock edge where in_valid_i is high and
// in_stall_o is low. One result item per input leaves on out_data_o with out_valid_o
// and transfers when out_stall_i is low.
// Each reduction runs the binary gcd unit (one step per cycle) and then the bit-serial
// divider; a, b and the result are reduced in turn (only a in normalise mode, a and b in
// compare mode), so these loops set the rate. One item is processed at a time;
// in_stall_o is high from the cycle after a transfer until the result is written to the
// output register.
// The output register holds a finished result while out_stall_i is high; the next
// item may be accepted meanwhile, and its result waits for the register to drain.
// Reset clears the controller and the output valid flag; the datapath needs none.
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rau_pkg::rau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // Sequencing: accept, check operands, reduce, multiply, reduce result, transfer.
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic: operand registers, multiplier, gcd and divider, output register.
  rau_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
